[src/ncbv_pkg.sv]
// shared types and constants for the cascaded band-pass noise voice
package ncbv_pkg;

    localparam int SECTIONS_DEF = 2;

    localparam int NOISE_W = 16;
    localparam int ENV_W   = 17;
    localparam int MIX_W   = 24;
    localparam int DATA_W  = 24;
    localparam int COEF_W  = 20;
    localparam int GAIN_W  = 16;
    localparam int NUM_COEF = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // shared multiplier operand widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0   = 3'd0,
        CFG_B1   = 3'd1,
        CFG_B2   = 3'd2,
        CFG_A1   = 3'd3,
        CFG_A2   = 3'd4,
        CFG_GAIN = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_B0   = 3'd0,
        OP_B1   = 3'd1,
        OP_B2   = 3'd2,
        OP_A1   = 3'd3,
        OP_A2   = 3'd4,
        OP_GAIN = 3'd5,
        OP_ENV  = 3'd6
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        mul_op_t mul_op;
        logic    acc_clr;
        logic    acc_add;
        logic    sec_update;
        logic    clip_load;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

[src/ncbv_ctrl.sv]
// sequencing state machine for the shared-multiplier filter datapath
module ncbv_ctrl #(
    parameter int SECTIONS = ncbv_pkg::SECTIONS_DEF,
    parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ncbv_pkg::dp_status_t status,
    output ncbv_pkg::ctrl_cmd_t  cmd,
    output logic [SEC_W-1:0]     sec_idx
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MAC  = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_SEC  = 8'b0000_1000,
        S_GMUL = 8'b0001_0000,
        S_CLIP = 8'b0010_0000,
        S_EMUL = 8'b0100_0000,
        S_MIX  = 8'b1000_0000
    } state_t;

    localparam logic [2:0]       LAST_TERM = 3'(ncbv_pkg::NUM_COEF - 1);
    localparam logic [SEC_W-1:0] LAST_SEC  = SEC_W'(SECTIONS - 1);

    state_t            state_reg, state_next;
    logic [2:0]        term_reg, term_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            sec_reg   <= sec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        sec_next   = sec_reg;
        cmd        = '0;
        cmd.mul_op = ncbv_pkg::OP_B0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    term_next   = '0;
                    sec_next    = '0;
                    state_next  = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mul_en = 1'b1;
                case (term_reg)
                    3'd0:    cmd.mul_op = ncbv_pkg::OP_B0;
                    3'd1:    cmd.mul_op = ncbv_pkg::OP_B1;
                    3'd2:    cmd.mul_op = ncbv_pkg::OP_B2;
                    3'd3:    cmd.mul_op = ncbv_pkg::OP_A1;
                    default: cmd.mul_op = ncbv_pkg::OP_A2;
                endcase
                // first term clears, later terms fold in the previous product
                if (term_reg == 3'd0)
                    cmd.acc_clr = 1'b1;
                else
                    cmd.acc_add = 1'b1;
                if (term_reg == LAST_TERM)
                    state_next = S_ACC;
                else
                    term_next = term_reg + 3'd1;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_SEC;
            end
            S_SEC:
            begin
                cmd.sec_update = 1'b1;
                term_next      = '0;
                if (sec_reg == LAST_SEC)
                    state_next = S_GMUL;
                else
                begin
                    sec_next   = sec_reg + 1'b1;
                    state_next = S_MAC;
                end
            end
            S_GMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = ncbv_pkg::OP_GAIN;
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip_load = 1'b1;
                state_next    = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = ncbv_pkg::OP_ENV;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign sec_idx  = sec_reg;

endmodule

[src/ncbv_datapath.sv]
// registers, shared multiplier, accumulator and output stage
module ncbv_datapath #(
    parameter int SECTIONS = ncbv_pkg::SECTIONS_DEF,
    parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ncbv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ncbv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ncbv_pkg::NOISE_W-1:0]        noise_word,
    input  logic [ncbv_pkg::ENV_W-1:0]          envelope_level,
    input  logic signed [ncbv_pkg::MIX_W-1:0]   mix_in,
    input  ncbv_pkg::ctrl_cmd_t                 cmd,
    input  logic [SEC_W-1:0]                    sec_idx,
    output ncbv_pkg::dp_status_t                status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic signed [ncbv_pkg::MIX_W-1:0]   mix_out,
    output logic                                clip_flag
);

    localparam int DW = ncbv_pkg::DATA_W;
    localparam int PW = ncbv_pkg::PROD_W;
    localparam int AW = ncbv_pkg::ACC_W;
    localparam int MW = ncbv_pkg::MIX_W;

    localparam logic signed [31:0]   DATA_MAX  = 32'sd8388607;
    localparam logic signed [31:0]   DATA_MIN  = -32'sd8388608;
    localparam logic signed [PW-1:0] UNITY_POS = PW'(64'sd16777216);
    localparam logic signed [PW-1:0] UNITY_NEG = PW'(-64'sd16777216);

    logic signed [ncbv_pkg::COEF_W-1:0] coef_reg [ncbv_pkg::NUM_COEF];
    logic [ncbv_pkg::GAIN_W-1:0]        gain_reg;

    logic signed [DW-1:0] in_d1_reg  [SECTIONS];
    logic signed [DW-1:0] in_d2_reg  [SECTIONS];
    logic signed [DW-1:0] out_d1_reg [SECTIONS];
    logic signed [DW-1:0] out_d2_reg [SECTIONS];

    logic signed [DW-1:0]             x_reg;
    logic [ncbv_pkg::ENV_W-1:0]       env_reg;
    logic signed [MW-1:0]             mix_reg;
    logic signed [PW-1:0]             prod_reg;
    logic signed [AW-1:0]             acc_reg;
    logic signed [ncbv_pkg::MUL_A_W-1:0] g_reg;
    logic                             clip_reg;
    logic signed [MW-1:0]             out_mix_reg;
    logic                             out_clip_reg;
    logic                             out_valid_reg;

    logic signed [ncbv_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ncbv_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                prod_next;
    logic signed [ncbv_pkg::NOISE_W-1:0] noise_s;
    logic signed [AW-1:0]                acc_rnd;
    logic signed [31:0]                  acc_q;
    logic signed [DW-1:0]                sec_y;
    logic signed [PW-1:0]                env_rnd;
    logic signed [20:0]                  env_e;
    logic signed [MW:0]                  mix_sum;
    logic signed [MW-1:0]                mix_sat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ncbv_pkg::NUM_COEF; i++)
                coef_reg[i] <= '0;
            gain_reg <= ncbv_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ncbv_pkg::CFG_B0:   coef_reg[0] <= cfg_data;
                ncbv_pkg::CFG_B1:   coef_reg[1] <= cfg_data;
                ncbv_pkg::CFG_B2:   coef_reg[2] <= cfg_data;
                ncbv_pkg::CFG_A1:   coef_reg[3] <= cfg_data;
                ncbv_pkg::CFG_A2:   coef_reg[4] <= cfg_data;
                ncbv_pkg::CFG_GAIN: gain_reg    <= cfg_data[ncbv_pkg::GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            ncbv_pkg::OP_B0:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(x_reg);
                mul_b = coef_reg[0];
            end
            ncbv_pkg::OP_B1:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(in_d1_reg[sec_idx]);
                mul_b = coef_reg[1];
            end
            ncbv_pkg::OP_B2:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(in_d2_reg[sec_idx]);
                mul_b = coef_reg[2];
            end
            ncbv_pkg::OP_A1:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(out_d1_reg[sec_idx]);
                mul_b = coef_reg[3];
            end
            ncbv_pkg::OP_A2:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(out_d2_reg[sec_idx]);
                mul_b = coef_reg[4];
            end
            ncbv_pkg::OP_GAIN:
            begin
                mul_a = ncbv_pkg::MUL_A_W'(x_reg);
                mul_b = $signed({4'b0000, gain_reg});
            end
            ncbv_pkg::OP_ENV:
            begin
                mul_a = g_reg;
                mul_b = $signed({3'b000, env_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // q1.15 noise sample, doubled into q8.16
    assign noise_s = $signed(noise_word ^ 16'h8000);

    // section output: round half up to q8.16, saturate to 24 bits
    assign acc_rnd = acc_reg + AW'(32768);
    assign acc_q   = acc_rnd[AW-1:16];
    always_comb
    begin
        if (acc_q > DATA_MAX)
            sec_y = DW'(DATA_MAX);
        else if (acc_q < DATA_MIN)
            sec_y = DW'(DATA_MIN);
        else
            sec_y = acc_q[DW-1:0];
    end

    // enveloped sample rounded to q1.15, then saturating mix add
    assign env_rnd = prod_reg + PW'(64'sd16777216);
    assign env_e   = env_rnd[PW-1:25];
    assign mix_sum = {mix_reg[MW-1], mix_reg} + {{(MW - 20){env_e[20]}}, env_e};
    always_comb
    begin
        if (mix_sum[MW] != mix_sum[MW-1])
            mix_sat = mix_sum[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
        else
            mix_sat = mix_sum[MW-1:0];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg   <= {{(DW - ncbv_pkg::NOISE_W - 1){noise_s[ncbv_pkg::NOISE_W-1]}},
                        noise_s, 1'b0};
            env_reg <= envelope_level;
            mix_reg <= mix_in;
        end
        else if (cmd.sec_update)
            x_reg <= sec_y;

        if (cmd.mul_en)
            prod_reg <= prod_next;

        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + AW'(prod_reg);

        if (cmd.clip_load)
        begin
            if (prod_reg > UNITY_POS)
            begin
                g_reg    <= UNITY_POS[ncbv_pkg::MUL_A_W-1:0];
                clip_reg <= 1'b1;
            end
            else if (prod_reg < UNITY_NEG)
            begin
                g_reg    <= UNITY_NEG[ncbv_pkg::MUL_A_W-1:0];
                clip_reg <= 1'b1;
            end
            else
            begin
                g_reg    <= prod_reg[ncbv_pkg::MUL_A_W-1:0];
                clip_reg <= 1'b0;
            end
        end

        if (cmd.out_load)
        begin
            out_mix_reg  <= mix_sat;
            out_clip_reg <= clip_reg;
        end
    end

    // per-section delay lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SECTIONS; i++)
            begin
                in_d1_reg[i]  <= '0;
                in_d2_reg[i]  <= '0;
                out_d1_reg[i] <= '0;
                out_d2_reg[i] <= '0;
            end
        end
        else if (cmd.sec_update)
        begin
            in_d2_reg[sec_idx]  <= in_d1_reg[sec_idx];
            in_d1_reg[sec_idx]  <= x_reg;
            out_d2_reg[sec_idx] <= out_d1_reg[sec_idx];
            out_d1_reg[sec_idx] <= sec_y;
        end
    end

    // output holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_full = out_valid_reg & ~m_tready;
    assign m_tvalid        = out_valid_reg;
    assign mix_out         = out_mix_reg;
    assign clip_flag       = out_clip_reg;

endmodule

[src/noise_cascaded_bandpass_voice_core.sv]
// top level of the cascaded band-pass noise voice
//
// one noise word per audio sample is centered to q1.15, filtered through
// SECTIONS cascaded biquad sections sharing one coefficient set (b0 b1 b2 a1 a2,
// feedback terms added), scaled by the q8.8 gain, clipped to +-1.0 (clip_flag
// marks it), scaled by the per-sample q1.16 envelope and added to mix_in with
// 24-bit saturation. every product goes through one shared 26x20 multiplier,
// so each item is worked through step by step from accept to result: five
// products plus accumulate and round per section, then gain, clip, envelope
// and mix. items are handled one at a time; the result sits in an output
// register, so the next transaction is accepted while it waits, and the mix
// step holds only if the previous result is still untaken.
// configuration writes take effect at once and belong in idle periods.
module noise_cascaded_bandpass_voice_core #(
    parameter int SECTIONS = ncbv_pkg::SECTIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port: 0..4 coefficients b0 b1 b2 a1 a2, 5 gain
    input  logic                                cfg_we,
    input  logic [ncbv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ncbv_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] noise_word, [32:16] envelope_level, [56:33] mix_in, rest zero
    input  logic [ncbv_pkg::S_TDATA_W-1:0]      s_tdata,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [23:0] mix_out, [24] clip_flag, rest zero
    output logic [ncbv_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    ncbv_pkg::ctrl_cmd_t            cmd;
    ncbv_pkg::dp_status_t           status;
    logic [SEC_W-1:0]               sec_idx;
    logic signed [ncbv_pkg::MIX_W-1:0] mix_out;
    logic                           clip_flag;

    // sequencer
    ncbv_ctrl #(
        .SECTIONS (SECTIONS),
        .SEC_W    (SEC_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .sec_idx  (sec_idx)
    );

    // filter, gain, envelope and mix datapath
    ncbv_datapath #(
        .SECTIONS (SECTIONS),
        .SEC_W    (SEC_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .noise_word     (s_tdata[15:0]),
        .envelope_level (s_tdata[32:16]),
        .mix_in         ($signed(s_tdata[56:33])),
        .cmd            (cmd),
        .sec_idx        (sec_idx),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .mix_out        (mix_out),
        .clip_flag      (clip_flag)
    );

    // pack result transaction, lowest field first
    assign m_tdata = {7'b0000000, clip_flag, mix_out};

endmodule

[test/noise_cascaded_bandpass_voice_core_tb.sv]
// self-checking stream testbench for the cascaded band-pass noise voice core
`timescale 1ns / 1ps

module noise_cascaded_bandpass_voice_core_tb;
    import ncbv_pkg::*;

    localparam int    SECTION_COUNT = SECTIONS_DEF;
    localparam int    CFG_SLOTS     = 1 << CFG_IDX_W;
    localparam int    SETTLE_CYCLES = 40;   // idle time added after the last result is back
    localparam int    LONG_HOLD     = 400;
    localparam int    STALL_LIMIT   = 4000;
    localparam int    MAX_PRINTED   = 200;
    localparam int    RANDOM_ITEMS  = 200;  // per random phase, five phases
    localparam int    NOISE_CENTER  = 32768;
    localparam int    ENV_UNITY     = 65536;
    localparam int    ENV_TOP       = (1 << ENV_W) - 1;
    localparam int    GAIN_UNITY    = 256;
    localparam int    GAIN_TOP      = (1 << GAIN_W) - 1;
    localparam int    COEF_UNITY    = 65536;
    localparam int    COEF_MAX      = (1 << (COEF_W - 1)) - 1;
    localparam int    COEF_MIN      = -(1 << (COEF_W - 1));
    localparam int    MIX_MAX_I     = (1 << (MIX_W - 1)) - 1;
    localparam int    MIX_MIN_I     = -(1 << (MIX_W - 1));
    localparam longint SECTION_HALF = 64'sd1 << 15;
    localparam longint ENV_HALF     = 64'sd1 << 24;
    localparam longint CLIP_LEVEL   = 64'sd1 << 24;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    typedef struct {
        logic [MIX_W-1:0] mix;
        logic             clip;
    } mix_result_t;

    // bit-exact model of the voice plus the queue of results still owed
    class voice_scoreboard;
        longint      coef[NUM_COEF];
        longint      gain;
        longint      in_d1[SECTION_COUNT];
        longint      in_d2[SECTION_COUNT];
        longint      out_d1[SECTION_COUNT];
        longint      out_d2[SECTION_COUNT];
        mix_result_t expected_mix[$];
        int          mismatches;
        int          result_index;

        function new();
            foreach (coef[i]) coef[i] = 0;
            gain = longint'(GAIN_RESET);
            foreach (in_d1[i])
            begin
                in_d1[i]  = 0;
                in_d2[i]  = 0;
                out_d1[i] = 0;
                out_d2[i] = 0;
            end
            mismatches   = 0;
            result_index = 0;
        endfunction

        function void set_register(int idx, cfg_word_t value);
            case (cfg_idx_t'(idx))
                CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2:
                    coef[idx] = longint'($signed(value[COEF_W-1:0]));
                CFG_GAIN:
                    gain = longint'(value[GAIN_W-1:0]);
                default: ;  // unused indexes are dropped
            endcase
        endfunction

        function longint clamp_data(longint v);
            if (v > MIX_MAX_I) return longint'(MIX_MAX_I);
            if (v < MIX_MIN_I) return longint'(MIX_MIN_I);
            return v;
        endfunction

        // runs one sample through the cascade, gain, clip, envelope and mix
        function void predict_mix_sample(logic [NOISE_W-1:0] noise_word,
                                         logic [ENV_W-1:0] env_level,
                                         logic [MIX_W-1:0] mix_in);
            longint      x;
            longint      acc;
            longint      y;
            longint      g;
            longint      e;
            mix_result_t r;
            r.clip = 1'b0;
            // q1.15 sample doubled into q8.16
            x = (longint'(noise_word) - NOISE_CENTER) * 2;
            for (int s = 0; s < SECTION_COUNT; s++)
            begin
                acc = coef[CFG_B0] * x + coef[CFG_B1] * in_d1[s] + coef[CFG_B2] * in_d2[s]
                    + coef[CFG_A1] * out_d1[s] + coef[CFG_A2] * out_d2[s];
                y = clamp_data((acc + SECTION_HALF) >>> 16);
                in_d2[s]  = in_d1[s];
                in_d1[s]  = x;
                out_d2[s] = out_d1[s];
                out_d1[s] = y;
                x = y;
            end
            g = x * gain;
            if (g > CLIP_LEVEL)
            begin
                g = CLIP_LEVEL;
                r.clip = 1'b1;
            end
            else if (g < -CLIP_LEVEL)
            begin
                g = -CLIP_LEVEL;
                r.clip = 1'b1;
            end
            e = (g * longint'(env_level) + ENV_HALF) >>> 25;
            r.mix = MIX_W'(clamp_data(longint'($signed(mix_in)) + e));
            expected_mix.push_back(r);
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED)
                $display("error at result %0d: %s", result_index, what);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] word);
            mix_result_t want;
            if (expected_mix.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with nothing expected", word));
            end
            else
            begin
                want = expected_mix.pop_front();
                if (word[MIX_W-1:0] !== want.mix)
                    report_mismatch($sformatf("mix_out %h, expected %h",
                                              word[MIX_W-1:0], want.mix));
                if (word[MIX_W] !== want.clip)
                    report_mismatch($sformatf("clip_flag %b, expected %b",
                                              word[MIX_W], want.clip));
            end
            result_index++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    voice_scoreboard board = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    int quiet_cycles;

    noise_cascaded_bandpass_voice_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random back-pressure, plus a long hold-off when asked for
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // every output transaction is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // writes all slots, the unused ones with junk; called at a falling edge
    task automatic load_settings(int b0, int b1, int b2, int a1, int a2, int gain_val);
        cfg_word_t values[CFG_SLOTS];
        for (int i = 0; i < CFG_SLOTS; i++)
            values[i] = CFG_DATA_W'($urandom);
        values[CFG_B0]   = CFG_DATA_W'(b0);
        values[CFG_B1]   = CFG_DATA_W'(b1);
        values[CFG_B2]   = CFG_DATA_W'(b2);
        values[CFG_A1]   = CFG_DATA_W'(a1);
        values[CFG_A2]   = CFG_DATA_W'(a2);
        values[CFG_GAIN] = CFG_DATA_W'(gain_val);
        for (int i = 0; i < CFG_SLOTS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            board.set_register(i, values[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // offers one input transaction and returns at the falling edge after it
    task automatic send_sample(logic [NOISE_W-1:0] noise_word, logic [ENV_W-1:0] env_level,
                               logic [MIX_W-1:0] mix_in);
        while (int'($urandom_range(99)) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - MIX_W - ENV_W - NOISE_W){1'b0}},
                     mix_in, env_level, noise_word};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.predict_mix_sample(noise_word, env_level, mix_in);
        @(negedge clk);
    endtask

    // sender pause until all results are back and the core is quiet
    task automatic drain;
        s_tvalid <= 1'b0;
        while (board.pending() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_samples(int count);
        logic [ENV_W-1:0] env;
        logic [MIX_W-1:0] mix;
        int               pick;
        for (int n = 0; n < count; n++)
        begin
            pick = int'($urandom_range(99));
            if (pick < 5)
                env = '0;
            else if (pick < 10)
                env = ENV_W'(ENV_UNITY);
            else if (pick < 15)
                env = ENV_W'($urandom_range(ENV_TOP, ENV_UNITY));
            else
                env = ENV_W'($urandom_range(ENV_UNITY));
            pick = int'($urandom_range(99));
            if (pick < 4)
                mix = MIX_W'(MIX_MAX_I);
            else if (pick < 8)
                mix = MIX_W'(MIX_MIN_I);
            else
                mix = MIX_W'($urandom);
            send_sample(NOISE_W'($urandom), env, mix);
        end
    endtask

    // resonant-ish section with a moderate gain
    task automatic load_bandpass;
        int b0;
        b0 = rand_between(-20000, 20000);
        load_settings(b0, rand_between(-4000, 4000), -b0,
                      rand_between(-2 * COEF_UNITY, 2 * COEF_UNITY),
                      rand_between(-COEF_UNITY + 2000, -20000),
                      rand_between(GAIN_UNITY, 8192));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle_pct  = 15;
        rx_idle_pct  = 15;
        hold_request = 1'b0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero coefficients, so the mix passes straight through
        send_sample(16'hffff, ENV_W'(ENV_UNITY), MIX_W'(MIX_MAX_I));
        send_sample(16'h0000, ENV_W'(ENV_UNITY), MIX_W'(MIX_MIN_I));
        send_sample(16'h1234, ENV_W'(ENV_TOP), '0);
        drain();

        // unity pass-through: noise doubling, rounding half up, envelope above one,
        // and mix saturation both ways
        load_settings(COEF_UNITY, 0, 0, 0, 0, GAIN_UNITY);
        send_sample(16'h0000, ENV_W'(ENV_UNITY), '0);
        send_sample(16'hffff, ENV_W'(ENV_UNITY), '0);
        send_sample(16'h8000, ENV_W'(ENV_UNITY), '0);
        send_sample(16'h8001, ENV_W'(ENV_UNITY), '0);
        send_sample(16'h8001, ENV_W'(ENV_UNITY / 2), '0);
        send_sample(16'h7fff, ENV_W'(ENV_UNITY / 2), '0);
        send_sample(16'hffff, ENV_W'(ENV_TOP), MIX_W'(MIX_MAX_I));
        send_sample(16'h0000, ENV_W'(ENV_TOP), MIX_W'(MIX_MIN_I));
        send_sample(16'hc000, 17'd1, '0);
        drain();

        // largest coefficients and gain: sections saturate, gain clips
        load_settings(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, GAIN_TOP);
        repeat (3) send_sample(16'hffff, ENV_W'(ENV_UNITY), '0);
        repeat (3) send_sample(16'h0000, ENV_W'(ENV_UNITY), '0);
        drain();

        // most negative coefficients with zero gain
        load_settings(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 0);
        send_sample(16'hffff, ENV_W'(ENV_TOP), 24'h123456);
        send_sample(16'h0000, ENV_W'(ENV_UNITY), 24'hedcba9);
        drain();

        load_bandpass();
        send_random_samples(RANDOM_ITEMS);
        drain();

        load_settings(rand_between(COEF_MIN, COEF_MAX), rand_between(COEF_MIN, COEF_MAX),
                      rand_between(COEF_MIN, COEF_MAX), rand_between(COEF_MIN, COEF_MAX),
                      rand_between(COEF_MIN, COEF_MAX), int'($urandom_range(GAIN_TOP)));
        send_random_samples(RANDOM_ITEMS);
        drain();

        // a long stretch with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_bandpass();
        send_random_samples(RANDOM_ITEMS);
        drain();
        tx_idle_pct = 15;
        rx_idle_pct = 15;

        // receiver holds off while the sender keeps offering, so the core backs up
        load_bandpass();
        hold_request = 1'b1;
        send_random_samples(RANDOM_ITEMS);
        drain();

        load_settings(rand_between(-COEF_UNITY, COEF_UNITY), rand_between(-COEF_UNITY, COEF_UNITY),
                      rand_between(-COEF_UNITY, COEF_UNITY), rand_between(-COEF_UNITY, COEF_UNITY),
                      rand_between(-COEF_UNITY, 0), int'($urandom_range(GAIN_TOP)));
        send_random_samples(RANDOM_ITEMS);
        drain();

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
